@@ rtl/core/edt_pkg.sv @@
package edt_pkg;

    // Nanoseconds per second, the scale of both divisions.
    localparam int unsigned NS_W = 30;
    localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;

    // Largest value the measured rate can hold.
    localparam logic [47:0] RATE_MAX = 48'hFFFF_FFFF_FFFF;

    // Width of the spacing product len * 1e9 and its left alignment in the dividend.
    localparam int unsigned DLY_BITS = 46;
    localparam int unsigned DLY_ALIGN = 64 - DLY_BITS;

    // Iteration counts of the divider.
    localparam logic [6:0] DIV_CNT_DLY = 7'd46;
    localparam logic [6:0] DIV_CNT_RATE = 7'd64;

    // Register values after reset.
    localparam logic [36:0] TARGET_RATE_RST = 37'd125000000;
    localparam logic [36:0] INITIAL_RATE_RST = 37'd125000000;
    localparam logic [39:0] MEASURE_INTERVAL_RST = 40'd100000000;
    localparam logic [39:0] MAX_AHEAD_RST = 40'd1000000000;

    // Configuration register indexes.
    typedef enum logic [7:0] {
        CFG_TARGET_RATE = 8'd0,
        CFG_INITIAL_RATE = 8'd1,
        CFG_MEASURE_INTERVAL = 8'd2,
        CFG_MAX_AHEAD = 8'd3
    } t_cfg_idx;

    // Packet event entering the pacer.
    typedef struct packed {
        logic [15:0] pkt_len;
        logic [63:0] now_ns;
        logic [63:0] req_stamp;
        logic        non_tcp_sock;
    } t_edt_in;

    // Verdict leaving the pacer.
    typedef struct packed {
        logic        verdict;
        logic [63:0] depart_stamp;
        logic [47:0] measured_rate;
        logic [63:0] packets_seen;
    } t_edt_out;

    // Request to the shared divider.
    typedef struct packed {
        logic        start;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [63:0] den;
        logic [6:0]  count;
    } t_div_req;

    // Answer from the shared divider.
    typedef struct packed {
        logic        done;
        logic [63:0] quot;
    } t_div_rsp;

endpackage

@@ rtl/core/edt_div.sv @@
module edt_div
    import edt_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic        r_busy;
    logic        r_done;
    logic [6:0]  r_cnt;
    logic [63:0] r_rem;
    logic [63:0] r_lo;
    logic [63:0] r_den;
    logic [63:0] r_quo;

    logic [64:0] n_shift;
    logic [64:0] n_diff;
    logic        n_ge;

    // One restoring step: shift in the next dividend bit and try the subtract.
    always_comb begin
        n_shift = {r_rem, r_lo[63]};
        n_diff  = n_shift - {1'b0, r_den};
        n_ge    = (n_shift >= {1'b0, r_den});
    end

    // Sequencing of the iterations.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Remainder, dividend and quotient words.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.hi;
            r_lo  <= i_req.lo;
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[63:0] : n_shift[63:0];
            r_lo  <= {r_lo[62:0], 1'b0};
            r_quo <= {r_quo[62:0], n_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quo;

endmodule

@@ rtl/core/edt_packet_pacer.sv @@
// Earliest-departure-time pacer for one flow, one packet at a time.
// A scheduled packet takes the multiplier and the delay division, a dropped one skips both;
// closing the measuring window adds a second pass (a saturated rate skips the division).
// Each pass uses the shared 32x30 multiplier and the one-bit-per-cycle divider (46 or 64 steps).
// One packet is taken at a time: the input stalls until the result
// is registered. Reset (synchronous, active low) clears the flow state and loads the defaults.
module edt_packet_pacer
    import edt_pkg::*;
#(
    parameter int unsigned COUNT_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_edt_in     i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_edt_out    o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);

    localparam int unsigned CW1 = COUNT_BITS + 1;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b00_0000_0001,
        S_DECIDE = 10'b00_0000_0010,
        S_MUL_LO = 10'b00_0000_0100,
        S_MUL_HI = 10'b00_0000_1000,
        S_COMB   = 10'b00_0001_0000,
        S_LOAD   = 10'b00_0010_0000,
        S_DIV    = 10'b00_0100_0000,
        S_POST   = 10'b00_1000_0000,
        S_ELAPSE = 10'b01_0000_0000,
        S_DONE   = 10'b10_0000_0000
    } t_state;

    t_state r_state;

    // Configuration registers.
    logic [36:0] r_target_rate;
    logic [36:0] r_initial_rate;
    logic [39:0] r_measure_interval;
    logic [39:0] r_max_ahead;

    // Flow state.
    logic [63:0]           r_last;
    logic [63:0]           r_wstart;
    logic [47:0]           r_rate;
    logic [COUNT_BITS-1:0] r_wbytes;
    logic [63:0]           r_total;

    // Latched packet and working registers.
    logic [15:0] r_len;
    logic [63:0] r_now;
    logic [63:0] r_stamp;
    logic        r_non_tcp;
    logic [63:0] r_send;
    logic        r_verdict;
    logic [63:0] r_depart;
    logic        r_op_rate;
    logic [63:0] r_mul_a;
    logic [61:0] r_p0;
    logic [61:0] r_p1;
    logic [63:0] r_hi;
    logic [63:0] r_lo;
    logic [63:0] r_den;
    logic [63:0] r_elapsed;

    // Output register.
    logic     r_out_valid;
    t_edt_out r_out;

    // Combinational helpers.
    logic                  n_rate_zero;
    logic [CW1-1:0]        n_wsum;
    logic [COUNT_BITS-1:0] n_wbytes;
    logic [63:0]           n_ahead;
    logic                  n_drop;
    logic [31:0]           n_mul_in;
    logic [61:0]           n_mul_out;
    logic [127:0]          n_prod;
    logic [64:0]           n_next_sum;
    logic [63:0]           n_next;
    logic [63:0]           n_elapsed;
    logic                  n_out_free;
    t_div_req              div_req;
    t_div_rsp              div_rsp;

    // The configuration port never holds a write off.
    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Entry: re-initialise on a zero rate, then count the packet.
    always_comb begin
        n_rate_zero = (r_rate == '0);
        n_wsum      = CW1'(n_rate_zero ? '0 : r_wbytes) + CW1'(i_in_data.pkt_len);
        n_wbytes    = n_wsum[COUNT_BITS] ? '1 : n_wsum[COUNT_BITS-1:0];
    end

    // Drop test for packets from a non-TCP socket.
    always_comb begin
        n_ahead = r_last - r_now;
        n_drop  = r_non_tcp && (r_last > r_now) && (n_ahead > 64'(r_max_ahead));
    end

    // Shared multiplier: one 32-bit half of the operand times 1e9 per cycle.
    always_comb begin
        n_mul_in  = (r_state == S_MUL_LO) ? r_mul_a[31:0] : r_mul_a[63:32];
        n_mul_out = 62'(n_mul_in) * 62'(NS_PER_S);
        n_prod    = {66'd0, r_p0} + {34'd0, r_p1, 32'd0};
    end

    // Schedule step and window age.
    always_comb begin
        n_next_sum = {1'b0, r_last} + {1'b0, div_rsp.quot};
        n_next     = n_next_sum[64] ? '1 : n_next_sum[63:0];
        n_elapsed  = r_now - r_wstart;
        n_out_free = !r_out_valid || !i_out_stall;
    end

    // Divider start, from the registered operands.
    always_comb begin
        div_req.start = (r_state == S_LOAD) && !(r_op_rate && (r_hi >= r_den));
        div_req.hi    = r_hi;
        div_req.lo    = r_lo;
        div_req.den   = r_den;
        div_req.count = r_op_rate ? DIV_CNT_RATE : DIV_CNT_DLY;
    end

    edt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_rate      <= TARGET_RATE_RST;
            r_initial_rate     <= INITIAL_RATE_RST;
            r_measure_interval <= MEASURE_INTERVAL_RST;
            r_max_ahead        <= MAX_AHEAD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_TARGET_RATE:      r_target_rate      <= i_cfg_data[36:0];
                CFG_INITIAL_RATE:     r_initial_rate     <= i_cfg_data[36:0];
                CFG_MEASURE_INTERVAL: r_measure_interval <= i_cfg_data[39:0];
                CFG_MAX_AHEAD:        r_max_ahead        <= i_cfg_data[39:0];
                default: ;
            endcase
        end
    end

    // Result valid: set when a result is registered, cleared by its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_DONE) && n_out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sequencer and flow state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_last      <= '0;
            r_wstart    <= '0;
            r_rate      <= '0;
            r_wbytes    <= '0;
            r_total     <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        if (n_rate_zero) begin
                            r_last   <= '0;
                            r_wstart <= i_in_data.now_ns;
                            r_rate   <= 48'(r_initial_rate);
                        end
                        r_wbytes <= n_wbytes;
                        if (r_total != '1) begin
                            r_total <= r_total + 64'd1;
                        end
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state <= n_drop ? S_ELAPSE : S_MUL_LO;
                end
                S_MUL_LO: r_state <= S_MUL_HI;
                S_MUL_HI: r_state <= S_COMB;
                S_COMB:   r_state <= S_LOAD;
                S_LOAD: begin
                    if (div_req.start) begin
                        r_state <= S_DIV;
                    end else begin
                        // The quotient cannot fit: the rate saturates.
                        r_rate   <= RATE_MAX;
                        r_wstart <= r_now;
                        r_wbytes <= '0;
                        r_state  <= S_DONE;
                    end
                end
                S_DIV: begin
                    if (div_rsp.done) begin
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (r_op_rate) begin
                        r_rate   <= (div_rsp.quot > 64'(RATE_MAX)) ? RATE_MAX
                                                                   : div_rsp.quot[47:0];
                        r_wstart <= r_now;
                        r_wbytes <= '0;
                        r_state  <= S_DONE;
                    end else begin
                        r_last  <= (n_next <= r_send) ? r_send : n_next;
                        r_state <= S_ELAPSE;
                    end
                end
                S_ELAPSE: begin
                    r_state <= (n_elapsed > 64'(r_measure_interval)) ? S_MUL_LO : S_DONE;
                end
                S_DONE: begin
                    if (n_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Packet fields and datapath working registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_len     <= i_in_data.pkt_len;
                r_now     <= i_in_data.now_ns;
                r_stamp   <= i_in_data.req_stamp;
                r_non_tcp <= i_in_data.non_tcp_sock;
            end
            S_DECIDE: begin
                r_send    <= (r_stamp < r_now) ? r_now : r_stamp;
                r_verdict <= n_drop;
                r_depart  <= r_stamp;
                r_op_rate <= 1'b0;
                r_mul_a   <= 64'(r_len);
            end
            S_MUL_LO: r_p0 <= n_mul_out;
            S_MUL_HI: r_p1 <= n_mul_out;
            S_COMB: begin
                if (r_op_rate) begin
                    r_hi  <= n_prod[127:64];
                    r_lo  <= n_prod[63:0];
                    r_den <= r_elapsed;
                end else begin
                    r_hi  <= '0;
                    r_lo  <= {n_prod[DLY_BITS-1:0], DLY_ALIGN'(0)};
                    r_den <= (r_target_rate == '0) ? 64'd1 : 64'(r_target_rate);
                end
            end
            S_POST: begin
                if (!r_op_rate && !(n_next <= r_send)) begin
                    r_depart <= n_next;
                end
            end
            S_ELAPSE: begin
                r_elapsed <= n_elapsed;
                r_op_rate <= 1'b1;
                r_mul_a   <= 64'(r_wbytes);
            end
            S_DONE: begin
                if (n_out_free) begin
                    r_out.verdict       <= r_verdict;
                    r_out.depart_stamp  <= r_depart;
                    r_out.measured_rate <= r_rate;
                    r_out.packets_seen  <= r_total;
                end
            end
            default: ;
        endcase
    end

endmodule

@@ bench/tb_edt_packet_pacer.sv @@
module tb_edt_packet_pacer;
    import edt_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned COUNT_W = 48;
    localparam logic [63:0] NS_PER_SEC = 64'd1_000_000_000;
    localparam logic [47:0] RATE_TOP = 48'hFFFF_FFFF_FFFF;
    localparam logic [COUNT_W-1:0] BYTES_TOP = {COUNT_W{1'b1}};
    localparam logic [36:0] TGT_RATE_DEF = 37'd125_000_000;
    localparam logic [36:0] INIT_RATE_DEF = 37'd125_000_000;
    localparam logic [39:0] INTERVAL_DEF = 40'd100_000_000;
    localparam logic [39:0] AHEAD_DEF = 40'd1_000_000_000;
    localparam logic [63:0] MAX37 = 64'h1F_FFFF_FFFF;
    localparam logic [63:0] MAX40 = 64'hFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    // An index past the register list; a write there must change nothing.
    localparam logic [7:0] CFG_IDX_SPARE = 8'hFF;
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned TAIL_CYCLES = 200;
    localparam int unsigned MAX_PRINTS = 100;

    typedef struct {
        t_edt_in  pkt;
        bit       typed;
        t_edt_out result;
    } dir_row_t;

    typedef struct {
        logic [63:0] rate_tgt;
        logic [63:0] rate_init;
        logic [63:0] interval;
        logic [63:0] ahead;
        int unsigned n_pkts;
        int unsigned step_hi;
    } cfg_set_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        o_in_stall;
    t_edt_in     in_data = '0;
    logic        o_out_valid;
    logic        out_stall = 1'b0;
    t_edt_out    o_out_data;
    logic        cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  cfg_index = '0;
    logic [63:0] cfg_data = '0;

    // Expectation that rides along with the packet being offered.
    bit          row_typed = 1'b0;
    t_edt_out    row_result = '0;

    // Predictor copy of the registers and the flow state.
    logic [36:0]        tgt_rate;
    logic [36:0]        init_rate;
    logic [39:0]        meas_int;
    logic [39:0]        ahead_max;
    logic [63:0]        flow_last;
    logic [63:0]        flow_win_start;
    logic [47:0]        flow_rate;
    logic [COUNT_W-1:0] flow_bytes;
    logic [63:0]        flow_pkts;

    t_edt_out    pending_verdicts[$];
    t_edt_out    predicted;
    t_edt_out    want;
    int unsigned mismatches = 0;
    int unsigned quiet_cycles = 0;
    int unsigned tx_idle_pct = 30;
    int unsigned rx_idle_pct = 85;
    bit          rx_hold_req = 1'b0;
    int unsigned rx_hold_left = 0;
    logic [63:0] wall_ns;

    edt_packet_pacer #(
        .COUNT_BITS(COUNT_W)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(in_valid),
        .o_in_stall(o_in_stall),
        .i_in_data(in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data(o_out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data)
    );

    // Free-running clock, 2 ns period.
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("ERROR at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, exp_val);
        end
    endtask

    // Paces one packet: counts it, schedules or drops it, then closes the
    // measuring window when enough time has passed.
    function automatic t_edt_out pace_packet(input t_edt_in p);
        t_edt_out       res;
        logic [63:0]    send_at;
        logic [63:0]    delay;
        logic [64:0]    next_wide;
        logic [63:0]    next_at;
        logic [63:0]    elapsed;
        logic [36:0]    divisor;
        logic [COUNT_W:0] bytes_wide;
        logic [127:0]   scaled;
        logic [127:0]   quot;
        res.verdict = 1'b0;
        res.depart_stamp = p.req_stamp;

        // A zero measured rate means the flow starts over.
        if (flow_rate == '0) begin
            flow_last = '0;
            flow_win_start = p.now_ns;
            flow_rate = 48'(init_rate);
            flow_bytes = '0;
        end

        bytes_wide = {1'b0, flow_bytes} + (COUNT_W + 1)'(p.pkt_len);
        flow_bytes = bytes_wide[COUNT_W] ? BYTES_TOP : bytes_wide[COUNT_W-1:0];
        if (flow_pkts != ALL_ONES) begin
            flow_pkts = flow_pkts + 64'd1;
        end

        send_at = (p.req_stamp < p.now_ns) ? p.now_ns : p.req_stamp;
        if (p.non_tcp_sock && flow_last > p.now_ns
                && (flow_last - p.now_ns) > 64'(ahead_max)) begin
            res.verdict = 1'b1;
        end else begin
            divisor = (tgt_rate == '0) ? 37'd1 : tgt_rate;
            delay = (64'(p.pkt_len) * NS_PER_SEC) / 64'(divisor);
            next_wide = {1'b0, flow_last} + {1'b0, delay};
            next_at = next_wide[64] ? ALL_ONES : next_wide[63:0];
            if (next_at <= send_at) begin
                flow_last = send_at;
            end else begin
                res.depart_stamp = next_at;
                flow_last = next_at;
            end
        end

        // Rate measurement over the closing window, saturated to 48 bits.
        elapsed = p.now_ns - flow_win_start;
        if (elapsed > 64'(meas_int)) begin
            flow_win_start = p.now_ns;
            scaled = 128'(flow_bytes) * 128'(NS_PER_SEC);
            quot = scaled / 128'(elapsed);
            flow_rate = (quot > 128'(RATE_TOP)) ? RATE_TOP : quot[47:0];
            flow_bytes = '0;
        end

        res.measured_rate = flow_rate;
        res.packets_seen = flow_pkts;
        return res;
    endfunction

    // Monitor: tracks register writes, predicts each accepted packet and
    // checks each result transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tgt_rate <= TGT_RATE_DEF;
            init_rate <= INIT_RATE_DEF;
            meas_int <= INTERVAL_DEF;
            ahead_max <= AHEAD_DEF;
            flow_last <= '0;
            flow_win_start <= '0;
            flow_rate <= '0;
            flow_bytes <= '0;
            flow_pkts <= '0;
        end else begin
            if (cfg_valid && o_cfg_ready) begin
                case (cfg_index)
                    CFG_TARGET_RATE: tgt_rate = cfg_data[36:0];
                    CFG_INITIAL_RATE: init_rate = cfg_data[36:0];
                    CFG_MEASURE_INTERVAL: meas_int = cfg_data[39:0];
                    CFG_MAX_AHEAD: ahead_max = cfg_data[39:0];
                    default: ;
                endcase
            end
            if (in_valid && !o_in_stall) begin
                predicted = pace_packet(in_data);
                pending_verdicts.push_back(row_typed ? row_result : predicted);
            end
            if (o_out_valid && !out_stall) begin
                if (pending_verdicts.size() == 0) begin
                    report_mismatch("result with no packet pending",
                                    o_out_data.depart_stamp, '0);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (o_out_data.verdict !== want.verdict)
                        report_mismatch("verdict", 64'(o_out_data.verdict), 64'(want.verdict));
                    if (o_out_data.depart_stamp !== want.depart_stamp)
                        report_mismatch("depart_stamp", o_out_data.depart_stamp,
                                        want.depart_stamp);
                    if (o_out_data.measured_rate !== want.measured_rate)
                        report_mismatch("measured_rate", 64'(o_out_data.measured_rate),
                                        64'(want.measured_rate));
                    if (o_out_data.packets_seen !== want.packets_seen)
                        report_mismatch("packets_seen", o_out_data.packets_seen,
                                        want.packets_seen);
                end
            end
        end
    end

    // Receiver: random stalls, or one long hold-off when requested.
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_req = 1'b0;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left != 0) begin
            rx_hold_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
        end
    end

    // Watchdog on cycles without any transfer.
    always @(posedge i_clk) begin
        if ((in_valid && !o_in_stall) || (o_out_valid && !out_stall)
                || (cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offers one packet, after a random gap, and waits for its transfer.
    task automatic send_pkt(input t_edt_in pkt, input bit typed, input t_edt_out res);
        if ($urandom_range(0, 99) < tx_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < tx_idle_pct) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= pkt;
        row_typed <= typed;
        row_result <= res;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    // Stops offering and waits until every predicted result has arrived.
    task automatic settle_results();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_verdicts.size() != 0) @(posedge i_clk);
    endtask

    // One register write; bits above the register width carry noise.
    task automatic write_reg(input logic [7:0] idx, input logic [63:0] value,
                             input int unsigned width);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= ({$urandom, $urandom} << width) | value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    function automatic dir_row_t mk_row(input logic [15:0] len, input logic [63:0] now,
                                        input logic [63:0] stamp, input logic nt,
                                        input bit typed = 1'b0,
                                        input t_edt_out res = '0);
        dir_row_t r;
        r.pkt.pkt_len = len;
        r.pkt.now_ns = now;
        r.pkt.req_stamp = stamp;
        r.pkt.non_tcp_sock = nt;
        r.typed = typed;
        r.result = res;
        return r;
    endfunction

    // Random packet on a mostly forward-moving clock, with some noise.
    function automatic t_edt_in make_pkt(input int unsigned step_hi);
        t_edt_in     p;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5) begin
            p.now_ns = {$urandom, $urandom};
        end else begin
            if (pick < 10) begin
                wall_ns = wall_ns - 64'($urandom_range(0, 5000));
            end else if (pick < 18) begin
                wall_ns = wall_ns + ({$urandom, $urandom} >> $urandom_range(20, 40));
            end else begin
                wall_ns = wall_ns + 64'($urandom_range(0, step_hi));
            end
            p.now_ns = wall_ns;
        end

        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            p.req_stamp = '0;
        end else if (pick < 70) begin
            p.req_stamp = p.now_ns + 64'($urandom_range(0, 3 * step_hi));
        end else if (pick < 85) begin
            p.req_stamp = p.now_ns - 64'($urandom_range(0, step_hi));
        end else begin
            p.req_stamp = {$urandom, $urandom};
        end

        pick = $urandom_range(0, 99);
        if (pick < 50) begin
            p.pkt_len = 16'($urandom_range(0, 65535));
        end else if (pick < 80) begin
            p.pkt_len = 16'($urandom_range(40, 1500));
        end else if (pick < 90) begin
            p.pkt_len = '0;
        end else begin
            p.pkt_len = 16'hFFFF;
        end
        p.non_tcp_sock = 1'($urandom_range(0, 1));
        return p;
    endfunction

    initial begin
        dir_row_t    rows[$];
        cfg_set_t    sets[$];
        cfg_set_t    cs;
        int unsigned rand_done;
        rand_done = 0;
        wall_ns = 64'($urandom);

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed packets with the register defaults.
        rows.push_back(mk_row(16'd100, 64'd1000, 64'd0, 1'b0, 1'b1,
                              {1'b0, 64'd0, 48'd125000000, 64'd1}));
        rows.push_back(mk_row(16'd0, 64'd2000, 64'd0, 1'b0, 1'b1,
                              {1'b0, 64'd0, 48'd125000000, 64'd2}));
        rows.push_back(mk_row(16'hFFFF, 64'd3000, 64'd5000, 1'b0));
        rows.push_back(mk_row(16'd1500, 64'd3000, 64'd0, 1'b1));
        // A far timestamp is kept and pushes the schedule ahead.
        rows.push_back(mk_row(16'd64, 64'd4000, 64'd2_000_004_000, 1'b0));
        // Non-TCP packets now lead by more than the limit and are dropped.
        rows.push_back(mk_row(16'd64, 64'd5000, 64'd0, 1'b1));
        rows.push_back(mk_row(16'd64, 64'd5000, 64'd7, 1'b1));
        rows.push_back(mk_row(16'd64, 64'd6000, 64'd0, 1'b0));
        // Window closes and the rate is measured.
        rows.push_back(mk_row(16'd1000, 64'd200_000_000, 64'd0, 1'b0));
        // Time at its top: the rate measures to zero.
        rows.push_back(mk_row(16'hFFFF, ALL_ONES, ALL_ONES, 1'b0));
        // Restart after the zero rate, then the schedule saturates.
        rows.push_back(mk_row(16'd1000, ALL_ONES, 64'd0, 1'b0));
        rows.push_back(mk_row(16'd1000, ALL_ONES, 64'd0, 1'b0));
        // Time wraps past zero while the schedule sits at the top.
        rows.push_back(mk_row(16'd0, 64'd500_000_000, 64'd0, 1'b1));
        rows.push_back(mk_row(16'd0, 64'h4000_0000_1DCD_6500, 64'd0, 1'b0));
        rows.push_back(mk_row(16'd10, 64'h4000_0000_23C3_4600, 64'd0, 1'b0));
        rows.push_back(mk_row(16'hFFFF, 64'd0, 64'd0, 1'b0));
        rows.push_back(mk_row(16'h5555, 64'h5555_5555_5555_5555,
                              64'hAAAA_AAAA_AAAA_AAAA, 1'b0));
        rows.push_back(mk_row(16'hAAAA, 64'hAAAA_AAAA_AAAA_AAAA,
                              64'h5555_5555_5555_5555, 1'b1));
        foreach (rows[r]) send_pkt(rows[r].pkt, rows[r].typed, rows[r].result);
        settle_results();

        // Register settings for the random phases, extremes among them.
        cs = '{64'd1_000_000_000, 64'd1_000_000, 64'd20_000, 64'd3000, 120, 2000};
        sets.push_back(cs);
        cs = '{64'd0, 64'd0, 64'd0, 64'd0, 60, 1000};
        sets.push_back(cs);
        cs = '{MAX37, MAX37, MAX40, MAX40, 60, 1 << 20};
        sets.push_back(cs);
        cs = '{64'd1, 64'd1, 64'($urandom_range(0, 65535)),
               64'($urandom_range(0, 1 << 20)), 60, 5000};
        sets.push_back(cs);
        cs = '{({$urandom, $urandom} % MAX37) + 64'd1, {$urandom, $urandom} & MAX37,
               64'($urandom_range(0, 1 << 28)), 64'($urandom), 150, 100000};
        sets.push_back(cs);

        foreach (sets[s]) begin
            write_reg(CFG_TARGET_RATE, sets[s].rate_tgt, 37);
            write_reg(CFG_INITIAL_RATE, sets[s].rate_init, 37);
            write_reg(CFG_MEASURE_INTERVAL, sets[s].interval, 40);
            write_reg(CFG_MAX_AHEAD, sets[s].ahead, 40);
            if (s == 1) write_reg(CFG_IDX_SPARE, {$urandom, $urandom}, 64);
            cfg_valid <= 1'b0;
            @(posedge i_clk);

            for (int k = 0; k < sets[s].n_pkts; k++) begin
                // Idle mix: slow receiver, then slow sender, then none.
                if (rand_done < 150) begin
                    tx_idle_pct = 30;
                    rx_idle_pct = 85;
                end else if (rand_done < 300) begin
                    tx_idle_pct = 85;
                    rx_idle_pct = 30;
                end else begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
                // Back-pressure through the block, then a full drain.
                if (s == 0 && k == 40) rx_hold_req = 1'b1;
                if (s == 0 && k == 80) settle_results();
                send_pkt(make_pkt(sets[s].step_hi), 1'b0, '0);
                rand_done++;
            end
            settle_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
